[rtl/lcg_categorical_sampler_assert.svh]
// Assertion macros for the LCG categorical sampler.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LCG_CATEGORICAL_SAMPLER_ASSERT_SVH
`define LCG_CATEGORICAL_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define LCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCS_ASSERT_IMPL(lbl, ante, cons, msg)
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/lcs_pkg.sv]
// Shared types and codes for the LCG categorical sampler.
// No dependencies.
`default_nettype none
package lcs_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] CMD_SEED = 2'd0;
  localparam logic [1:0] CMD_WORD = 2'd1;
  localparam logic [1:0] CMD_FRAC = 2'd2;
  localparam logic [1:0] CMD_PROB = 2'd3;

  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_FRAC  = 2'd1;
  localparam logic [1:0] KIND_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC  = 2'd1;

  localparam logic [63:0] MULT_RESET = 64'd6364136223846793005;
  localparam logic [63:0] INC_RESET  = 64'd1442695040888963407;

  localparam logic [24:0] SUM_MAX = 25'h1FF_FFFF;

  // Request to the generator unit
  typedef struct packed {
    logic load;
    logic step;
  } lcs_req_t;

  // Status from the generator unit
  typedef struct packed {
    logic busy;
    logic done;
  } lcs_sts_t;

endpackage
`default_nettype wire

[rtl/lcs_lcg.sv]
// Generator state and its iterative 64-bit multiply-add.
// Uses lcs_pkg; one 32x32 multiplier shared over four phases.
`default_nettype none
module lcs_lcg (
  input  logic             clk,
  input  logic             rst_n,
  input  lcs_pkg::lcs_req_t req,
  input  logic [63:0]      seed,
  input  logic [63:0]      mult,
  input  logic [63:0]      inc,
  output logic [63:0]      state,
  output lcs_pkg::lcs_sts_t sts
);
  import lcs_pkg::*;

  localparam logic [1:0] PH_LL  = 2'd0;
  localparam logic [1:0] PH_HL  = 2'd1;
  localparam logic [1:0] PH_LH  = 2'd2;
  localparam logic [1:0] PH_FIN = 2'd3;

  logic        busy_r;
  logic        done_r;
  logic [1:0]  ph_r;
  logic [63:0] gen_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (ph_r)
      PH_LL: begin
        mul_a = gen_r[31:0];
        mul_b = mult[31:0];
      end
      PH_HL: begin
        mul_a = gen_r[63:32];
        mul_b = mult[31:0];
      end
      default: begin
        mul_a = gen_r[31:0];
        mul_b = mult[63:32];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_LL;
      gen_r  <= '0;
    end else begin
      done_r <= busy_r && (ph_r == PH_FIN);
      if (req.load) begin
        gen_r <= seed;
      end
      if (!busy_r) begin
        if (req.step) begin
          busy_r <= 1'b1;
          ph_r   <= PH_LL;
        end
      end else begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == PH_FIN) begin
          gen_r  <= {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Partial products: low*low, then the two cross terms into the top half
  always_ff @(posedge clk) begin
    if (busy_r) begin
      prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
      unique case (ph_r)
        PH_HL:   acc_r <= prod_r + inc;
        PH_LH:   acc_r <= {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign state    = gen_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

[rtl/lcg_categorical_sampler.sv]
// LCG categorical sampler. One item is taken at a time: in_ready is low
// while an item is at work. Each generator advance runs through a single
// 32x32 multiplier in four phases. A result waits in the output register
// while the next item is accepted. The user must write the configuration
// (multiplier, increment) only while idle; the block does not enforce it.
`default_nettype none
`include "lcg_categorical_sampler_assert.svh"
module lcg_categorical_sampler #(
  parameter int unsigned MAX_ELEMENTS = 256,
  parameter int unsigned WARMUP_STEPS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [63:0]                   in_seed_value,
  input  logic [24:0]                   in_prob,
  input  logic                          in_last_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [31:0]                   out_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import lcs_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS);
  localparam int unsigned WARM_W = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_ELEMENTS - 1);
  localparam logic [WARM_W-1:0] WARM_INIT = WARM_W'(WARMUP_STEPS);
  localparam logic [WARM_W-1:0] WARM_ONE  = WARM_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_ELEM,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [63:0]       mult_r;
  logic [63:0]       inc_r;
  logic [1:0]        cmd_r;
  logic [24:0]       prob_r;
  logic              last_r;
  logic [WARM_W-1:0] warm_r;
  logic [24:0]       sum_r;
  logic [23:0]       target_r;
  logic [CNT_W-1:0]  count_r;
  logic              active_r;
  logic              emitted_r;
  logic [1:0]        res_kind_r;
  logic [31:0]       res_value_r;
  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [31:0]       out_value_r;

  lcs_req_t    gen_req;
  lcs_sts_t    gen_sts;
  logic [63:0] gen_state;
  logic        in_fire;
  logic [25:0] sum_wide;
  logic [24:0] sum_nxt;
  logic        hit;
  logic        out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Load the seed on the accepting beat; advance once per issue
  assign gen_req.load = in_fire && (in_cmd == CMD_SEED);
  assign gen_req.step = (state_r == S_ISSUE) && (warm_r != '0);

  lcs_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gen_req),
    .seed  (in_seed_value),
    .mult  (mult_r),
    .inc   (inc_r),
    .state (gen_state),
    .sts   (gen_sts)
  );

  // Saturating running sum and the reach-target test
  assign sum_wide = {1'b0, sum_r} + {1'b0, prob_r};
  assign sum_nxt  = sum_wide[25] ? SUM_MAX : sum_wide[24:0];
  assign hit      = !emitted_r && ((sum_nxt >= {1'b0, target_r}) || last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MULT_RESET;
      inc_r  <= INC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MULT) begin
        mult_r <= cfg_data;
      end else if (cfg_index == REG_INC) begin
        inc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      warm_r      <= '0;
      sum_r       <= '0;
      target_r    <= '0;
      count_r     <= '0;
      active_r    <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r       <= CMD_SEED;
      res_kind_r  <= KIND_WORD;
    end else begin
      // Drop the result once taken, unless a new one loads in its place
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r <= in_cmd;
            unique case (in_cmd)
              CMD_SEED: begin
                // Drop any distribution in progress
                active_r <= 1'b0;
                warm_r   <= WARM_INIT;
                state_r  <= S_ISSUE;
              end
              CMD_WORD, CMD_FRAC: begin
                warm_r  <= WARM_ONE;
                state_r <= S_ISSUE;
              end
              default: begin
                if (active_r) begin
                  state_r <= S_ELEM;
                end else begin
                  warm_r  <= WARM_ONE;
                  state_r <= S_ISSUE;
                end
              end
            endcase
          end
        end
        S_ISSUE: begin
          if (warm_r != '0) begin
            warm_r  <= warm_r - WARM_ONE;
            state_r <= S_WAIT;
          end else begin
            unique case (cmd_r)
              CMD_SEED: state_r <= S_IDLE;
              CMD_WORD: begin
                res_kind_r  <= KIND_WORD;
                res_value_r <= gen_state[63:32];
                state_r     <= S_EMIT;
              end
              CMD_FRAC: begin
                res_kind_r  <= KIND_FRAC;
                res_value_r <= {8'd0, gen_state[63:40]};
                state_r     <= S_EMIT;
              end
              default: begin
                // First element: draw the target and open the distribution
                target_r  <= gen_state[63:40];
                sum_r     <= '0;
                count_r   <= '0;
                emitted_r <= 1'b0;
                active_r  <= 1'b1;
                state_r   <= S_ELEM;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (gen_sts.done) begin
            state_r <= S_ISSUE;
          end
        end
        S_ELEM: begin
          sum_r <= sum_nxt;
          if (last_r) begin
            active_r <= 1'b0;
          end else if (count_r < CNT_LAST) begin
            count_r <= count_r + 1'b1;
          end
          if (hit) begin
            emitted_r   <= 1'b1;
            res_kind_r  <= KIND_INDEX;
            res_value_r <= 32'(count_r);
            state_r     <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_value_r <= res_value_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Element payload, captured on the accepting beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      prob_r <= in_prob;
      last_r <= in_last_element;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;

  `LCS_ASSERT_IMPL(a_busy_blocks_input, gen_sts.busy, !in_ready, "input taken while generator busy")
  `LCS_ASSERT_IMPL(a_done_in_wait, gen_sts.done, state_r == S_WAIT, "generator done outside wait")
  `LCS_ASSERT_IMPL(a_step_when_free, gen_req.step, !gen_sts.busy, "step issued while generator busy")
  `LCS_ASSERT_IMPL(a_elem_active, state_r == S_ELEM, active_r, "element handled with no distribution")

endmodule
`default_nettype wire

[dv/tb_lcg_categorical_sampler.sv]
// Self-checking testbench for lcg_categorical_sampler: generator draws, seeding,
// categorical sampling and register writes, checked against an in-bench predictor.
// Depends on lcs_pkg and the lcg_categorical_sampler RTL only.
module tb_lcg_categorical_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  localparam int unsigned MAX_ELEMENTS = 256;
  localparam int unsigned WARMUP_STEPS = 20;
  // A seed beat gives no result, so allow its whole warm-up to finish before
  // touching registers or declaring the run over.
  localparam int unsigned SEED_SETTLE  = 6 * WARMUP_STEPS + 40;
  localparam int unsigned ONE_Q24      = 1 << 24;
  localparam int unsigned SUM_LIMIT    = (1 << 25) - 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } draw_result_t;

  // Block ports; all inputs driven to known values from time zero.
  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_cmd          = CMD_SEED;
  logic [63:0]          in_seed_value   = '0;
  logic [24:0]          in_prob         = '0;
  logic                 in_last_element = 1'b0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [1:0]           out_kind;
  logic [31:0]          out_value;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_MULT;
  logic [63:0]          cfg_data        = '0;

  // Predictor state: our own copy of the generator, the sampler and the registers.
  logic [63:0]  gen_state;
  logic [63:0]  mult_reg;
  logic [63:0]  inc_reg;
  logic [24:0]  acc_sum;
  logic [23:0]  target_frac;
  int unsigned  elem_idx;
  bit           dist_open;
  bit           idx_sent;

  draw_result_t expected_draws[$];
  int unsigned  mismatch_count = 0;
  int unsigned  items_sent     = 0;

  // Idling knobs, in percent of cycles, and the long receiver hold-off request.
  int unsigned  sender_idle_pct = 0;
  int unsigned  sink_idle_pct   = 0;
  int unsigned  stall_request   = 0;
  int unsigned  stall_left      = 0;

  lcg_categorical_sampler #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .WARMUP_STEPS (WARMUP_STEPS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_seed_value   (in_seed_value),
    .in_prob         (in_prob),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One LCG step, modulo 2^64.
  function automatic void step_generator();
    gen_state = gen_state * mult_reg + inc_reg;
  endfunction

  // Apply one accepted input beat to the predictor and queue any result it causes.
  function automatic void predict_draw(input logic [1:0] cmd, input logic [63:0] seed,
                                       input logic [24:0] prob, input logic is_last);
    draw_result_t r;
    logic [25:0]  total;
    case (cmd)
      CMD_SEED: begin
        // Reseed and warm up; any distribution in flight is abandoned.
        gen_state = seed;
        repeat (WARMUP_STEPS) step_generator();
        dist_open = 1'b0;
      end
      CMD_WORD: begin
        step_generator();
        r.kind  = KIND_WORD;
        r.value = gen_state[63:32];
        expected_draws.push_back(r);
      end
      CMD_FRAC: begin
        step_generator();
        r.kind  = KIND_FRAC;
        r.value = {8'h00, gen_state[63:40]};
        expected_draws.push_back(r);
      end
      default: begin
        // First element of a distribution draws the target fraction.
        if (!dist_open) begin
          step_generator();
          target_frac = gen_state[63:40];
          acc_sum     = '0;
          elem_idx    = 0;
          idx_sent    = 1'b0;
          dist_open   = 1'b1;
        end
        total   = {1'b0, acc_sum} + {1'b0, prob};
        acc_sum = (total > 26'(SUM_LIMIT)) ? SUM_MAX : total[24:0];
        if (!idx_sent && (acc_sum >= {1'b0, target_frac} || is_last)) begin
          idx_sent = 1'b1;
          r.kind   = KIND_INDEX;
          r.value  = elem_idx;
          expected_draws.push_back(r);
        end
        // The index counter sticks at the top once the element limit is passed.
        if (is_last) dist_open = 1'b0;
        else if (elem_idx < MAX_ELEMENTS - 1) elem_idx++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver idling and checking
  // ---------------------------------------------------------------------------

  // Drive out_ready at each edge; a pending hold-off request wins over random idling.
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic note_mismatch(input string what, input draw_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected kind %0d value 0x%08h, got kind %0d value 0x%08h",
               $realtime, what, want.kind, want.value, out_kind, out_value);
  endtask

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    draw_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_draws.size() == 0) begin
        want = '0;
        note_mismatch("result with nothing expected", want);
      end else begin
        want = expected_draws.pop_front();
        if (out_kind !== want.kind || out_value !== want.value)
          note_mismatch("result mismatch", want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one input beat, idling first at random; hold valid high until accepted.
  // Valid is left high afterwards so back-to-back beats never drop it.
  task automatic send_item(input logic [1:0] cmd, input logic [63:0] seed,
                           input logic [24:0] prob, input logic is_last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_seed_value   <= seed;
    in_prob         <= prob;
    in_last_element <= is_last;
    do @(posedge clk); while (!in_ready);
    predict_draw(cmd, seed, prob, is_last);
    items_sent++;
  endtask

  // Drop valid, wait for every expected result, then let any seed warm-up finish.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (SEED_SETTLE) @(posedge clk);
  endtask

  // Write both registers in two back-to-back beats; call only with the block idle.
  task automatic write_registers(input logic [63:0] mult, input logic [63:0] inc);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MULT;
    cfg_data  <= mult;
    do @(posedge clk); while (!cfg_ready);
    mult_reg = mult;
    cfg_index <= REG_INC;
    cfg_data  <= inc;
    do @(posedge clk); while (!cfg_ready);
    inc_reg = inc;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked beats: draws, extremes of seed and probability, and the corner
  // cases of distributions (abandon by seed, draws mid-stream, early emit,
  // last element with the target unreached, saturation of the sum).
  task automatic test_directed_cases();
    send_item(CMD_WORD, '0, '0, 1'b0);           // draw from the all-zero state
    send_item(CMD_FRAC, '1, '1, 1'b1);           // unused fields at all ones
    send_item(CMD_PROB, '0, 25'd0, 1'b0);        // opens a distribution
    send_item(CMD_WORD, '0, '0, 1'b0);           // draw mid-distribution
    send_item(CMD_FRAC, '0, '0, 1'b0);
    send_item(CMD_PROB, '0, 25'(ONE_Q24), 1'b0); // probability of exactly one
    send_item(CMD_PROB, '0, SUM_MAX, 1'b0);      // sum saturates, index already out
    send_item(CMD_PROB, '0, SUM_MAX, 1'b1);      // closes silently
    send_item(CMD_SEED, 64'd0, '0, 1'b0);
    send_item(CMD_PROB, '0, 25'd0, 1'b0);
    send_item(CMD_PROB, '0, 25'd0, 1'b0);
    send_item(CMD_PROB, '0, 25'd0, 1'b1);        // target unreached: last index out
    send_item(CMD_SEED, '1, '0, 1'b1);
    send_item(CMD_PROB, '0, 25'd1, 1'b0);
    send_item(CMD_SEED, 64'h0123_4567_89AB_CDEF, '0, 1'b0); // abandons the stream
    send_item(CMD_PROB, '0, 25'd0, 1'b1);        // fresh one-element distribution
    send_item(CMD_FRAC, '0, '0, 1'b0);
    send_item(CMD_WORD, '0, '0, 1'b0);
    send_item(CMD_PROB, '0, 25'(ONE_Q24), 1'b1);
    send_item(CMD_PROB, '0, 25'(ONE_Q24 + 1), 1'b0); // above one, then overflow
    send_item(CMD_PROB, '0, SUM_MAX, 1'b1);
  endtask

  // Mostly well-formed distributions with random content, mixed with draws and
  // seeds, plus noise: draws or seeds inside a distribution and missing last marks.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned k;
    logic [24:0] prob;
    logic        is_last;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(CMD_SEED, {$urandom, $urandom}, 25'($urandom), 1'($urandom));
      end else if (pick < 18) begin
        send_item(CMD_WORD, {$urandom, $urandom}, 25'($urandom), 1'($urandom));
      end else if (pick < 30) begin
        send_item(CMD_FRAC, {$urandom, $urandom}, 25'($urandom), 1'($urandom));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(99);
          if (pick < 4)
            send_item(CMD_WORD, {$urandom, $urandom}, 25'($urandom), 1'($urandom));
          else if (pick < 6)
            send_item(CMD_FRAC, {$urandom, $urandom}, 25'($urandom), 1'($urandom));
          else if (pick < 7)
            send_item(CMD_SEED, {$urandom, $urandom}, 25'($urandom), 1'($urandom));
          pick = $urandom_range(19);
          if (pick == 0)      prob = '0;
          else if (pick == 1) prob = 25'(ONE_Q24);
          else if (pick == 2) prob = 25'($urandom_range(ONE_Q24 + 1, SUM_LIMIT));
          else                prob = 25'($urandom_range(0, (2 * ONE_Q24) / len));
          // Now and then leave the last mark off so the stream runs on.
          is_last = (k == len - 1) && ($urandom_range(19) != 0);
          send_item(CMD_PROB, {$urandom, $urandom}, prob, is_last);
        end
      end
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the output register fills and the input stalls; then drain.
  task automatic test_backpressure();
    stall_request = 400;
    test_random_traffic(40);
    drain_block();
  endtask

  // Run one distribution far past the element limit: the index sticks at the top.
  task automatic test_long_distribution();
    int unsigned k;
    send_item(CMD_SEED, {$urandom, $urandom}, '0, 1'b0);
    for (k = 0; k < MAX_ELEMENTS + 14; k++)
      send_item(CMD_PROB, '0, 25'd0, 1'b0);
    send_item(CMD_PROB, '0, 25'd0, 1'b1);
  endtask

  // Step through register extremes, each followed by a burst of traffic.
  task automatic test_register_settings();
    logic [63:0] mults[5];
    logic [63:0] incs[5];
    int unsigned s;
    mults = '{64'd0, '1, 64'd1, {$urandom, $urandom}, MULT_RESET};
    incs  = '{64'd0, '1, 64'd0, {$urandom, $urandom}, INC_RESET};
    for (s = 0; s < 5; s++) begin
      drain_block();
      write_registers(mults[s], incs[s]);
      send_item(CMD_SEED, {$urandom, $urandom}, '0, 1'b0);
      test_random_traffic(40);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Predictor starts from the reset state of the block.
    gen_state   = '0;
    mult_reg    = MULT_RESET;
    inc_reg     = INC_RESET;
    acc_sum     = '0;
    target_frac = '0;
    elem_idx    = 0;
    dist_open   = 1'b0;
    idx_sent    = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles lightly, receiver heavily.
    sender_idle_pct = 37;
    sink_idle_pct   = 84;
    test_directed_cases();
    test_random_traffic(300);

    // Phase two: roles swapped, under fresh random registers.
    drain_block();
    write_registers({$urandom, $urandom}, {$urandom, $urandom});
    sender_idle_pct = 84;
    sink_idle_pct   = 37;
    test_random_traffic(300);

    // Phase three: no idling at all.
    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    test_backpressure();
    test_long_distribution();
    test_register_settings();

    drain_block();
    if (mismatch_count == 0 && expected_draws.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_lcg.sv
rtl/lcg_categorical_sampler.sv
dv/tb_lcg_categorical_sampler.sv
